// ===== rtl/itp_pkg.sv =====
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int MAX_RESULTS = 32;

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);

  localparam logic [3:0] K_NUMBER = 4'd0;
  localparam logic [3:0] K_PLUS   = 4'd1;
  localparam logic [3:0] K_MINUS  = 4'd2;
  localparam logic [3:0] K_MULT   = 4'd3;
  localparam logic [3:0] K_DIV    = 4'd4;
  localparam logic [3:0] K_UNEG   = 4'd5;
  localparam logic [3:0] K_LPAREN = 4'd6;
  localparam logic [3:0] K_RPAREN = 4'd7;
  localparam logic [3:0] K_END    = 4'd8;

  localparam logic [2:0] OK_NUMBER = 3'd0;
  localparam logic [2:0] OK_UNEG   = 3'd5;
  localparam logic [2:0] OK_LPAREN = 3'd6;

  localparam logic [1:0] PREC_NONE = 2'd0;
  localparam logic [1:0] PREC_LOW  = 2'd1;
  localparam logic [1:0] PREC_MID  = 2'd2;
  localparam logic [1:0] PREC_HIGH = 2'd3;

  localparam logic ASSOC_LEFT  = 1'b0;
  localparam logic ASSOC_RIGHT = 1'b1;

  function automatic logic [1:0] prec_of(input logic [2:0] kind);
    logic [1:0] p;
    p = PREC_NONE;
    if (kind == K_PLUS[2:0] || kind == K_MINUS[2:0]) p = PREC_LOW;
    if (kind == K_MULT[2:0] || kind == K_DIV[2:0])   p = PREC_MID;
    if (kind == OK_UNEG)                              p = PREC_HIGH;
    return p;
  endfunction

  function automatic logic assoc_of(input logic [2:0] kind);
    return (kind == OK_UNEG) ? ASSOC_RIGHT : ASSOC_LEFT;
  endfunction

  // stacked entry leaves ahead of incoming operator
  function automatic logic pops(input logic [2:0] stacked, input logic [2:0] incoming);
    logic [1:0] tp;
    logic [1:0] p;
    tp = prec_of(stacked);
    p  = prec_of(incoming);
    return (tp != PREC_NONE) &&
           ((tp > p) || (tp == p && assoc_of(incoming) == ASSOC_LEFT));
  endfunction

endpackage

// ===== rtl/infix_to_postfix_converter.sv =====
// a number is captured into the token register on its transfer, then written to the output register once it is free
// each popped stack entry takes a pop in S_RUN, then a memory read in S_WAIT to refill the cache
// a new token is accepted only in S_IDLE, once the previous one and every stack entry it pops are done;
// a right parenthesis ends when it pops its matching left parenthesis, which is not emitted
// reset: synchronous; clears stack count, overflow flag, sequencer and output valid
// stack memory is not cleared; only written entries are ever used
module infix_to_postfix_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  token_kind,
  input  logic [31:0] token_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [31:0] out_value,
  output logic        run_last,
  output logic        expr_done,
  output logic        overflow_seen
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} state_t;

  state_t                              state, state_next;
  logic                                fin, fin_next;
  logic [3:0]                          kind_r;
  logic [itp_pkg::VALUE_WIDTH-1:0]     value_r;
  logic [itp_pkg::CNT_W-1:0]           count;
  logic [itp_pkg::RES_W-1:0]           n;
  logic                                flag;
  logic [2:0]                          top;
  logic [2:0]                          under;
  logic [2:0]                          rdata;
  logic [2:0]                          stack_mem [itp_pkg::STACK_DEPTH];
  logic [itp_pkg::ADDR_W-1:0]          rd_addr;

  logic       out_free;
  logic       room;
  logic       room_more;
  logic       emit;
  logic [2:0] emit_kind;
  logic       emit_last;
  logic       emit_done;
  logic       do_push;
  logic       do_pop;
  logic       do_clear;

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign room      = (n < itp_pkg::RES_W'(itp_pkg::MAX_RESULTS));
  assign room_more = (n < itp_pkg::RES_W'(itp_pkg::MAX_RESULTS - 1));
  assign rd_addr   = itp_pkg::ADDR_W'(count - itp_pkg::CNT_W'(3));

  always_comb begin
    state_next = state;
    fin_next   = fin;
    emit       = 1'b0;
    emit_kind  = top;
    emit_last  = 1'b0;
    emit_done  = 1'b0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_clear   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_RUN;
      end
      S_RUN: begin
        unique case (kind_r)
          itp_pkg::K_NUMBER: begin
            if (out_free) begin
              emit       = 1'b1;
              emit_kind  = itp_pkg::OK_NUMBER;
              emit_last  = 1'b1;
              state_next = S_IDLE;
            end
          end
          itp_pkg::K_PLUS, itp_pkg::K_MINUS, itp_pkg::K_MULT, itp_pkg::K_DIV,
          itp_pkg::K_UNEG: begin
            if (count != '0 && room && itp_pkg::pops(top, kind_r[2:0])) begin
              if (out_free) begin
                emit       = 1'b1;
                emit_last  = !(count > itp_pkg::CNT_W'(1) && room_more &&
                               itp_pkg::pops(under, kind_r[2:0]));
                do_pop     = 1'b1;
                fin_next   = 1'b0;
                state_next = S_WAIT;
              end
            end else begin
              do_push    = 1'b1;
              state_next = S_IDLE;
            end
          end
          itp_pkg::K_LPAREN: begin
            do_push    = 1'b1;
            state_next = S_IDLE;
          end
          itp_pkg::K_RPAREN: begin
            if (count == '0 || !room) begin
              state_next = S_IDLE;
            end else if (top == itp_pkg::OK_LPAREN) begin
              do_pop     = 1'b1;
              fin_next   = 1'b1;
              state_next = S_WAIT;
            end else if (out_free) begin
              emit       = 1'b1;
              emit_last  = (count == itp_pkg::CNT_W'(1)) || (under == itp_pkg::OK_LPAREN) ||
                           !room_more;
              do_pop     = 1'b1;
              fin_next   = 1'b0;
              state_next = S_WAIT;
            end
          end
          itp_pkg::K_END: begin
            if (count == '0 || !room) begin
              do_clear   = 1'b1;
              state_next = S_IDLE;
            end else if (out_free) begin
              emit       = 1'b1;
              emit_last  = (count == itp_pkg::CNT_W'(1)) || !room_more;
              emit_done  = emit_last;
              do_pop     = 1'b1;
              fin_next   = 1'b0;
              state_next = S_WAIT;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_WAIT: begin
        state_next = fin ? S_IDLE : S_RUN;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // operator stack memory
  always_ff @(posedge clk) begin
    if (do_push && count != itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH)) begin
      stack_mem[count[itp_pkg::ADDR_W-1:0]] <= kind_r[2:0];
    end
    rdata <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fin       <= 1'b0;
      count     <= '0;
      n         <= '0;
      flag      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fin   <= fin_next;
      if (in_valid && in_ready) begin
        kind_r  <= token_kind;
        value_r <= token_value[itp_pkg::VALUE_WIDTH-1:0];
        n       <= '0;
      end
      if (emit) begin
        n             <= n + itp_pkg::RES_W'(1);
        out_valid     <= 1'b1;
        out_kind      <= emit_kind;
        out_value     <= (emit_kind == itp_pkg::OK_NUMBER) ? 32'(value_r) : 32'd0;
        run_last      <= emit_last;
        expr_done     <= emit_done;
        overflow_seen <= flag;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (do_push) begin
        if (count == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH)) begin
          flag <= 1'b1;
        end else begin
          top   <= kind_r[2:0];
          under <= top;
          count <= count + itp_pkg::CNT_W'(1);
        end
      end
      if (do_pop) begin
        count <= count - itp_pkg::CNT_W'(1);
        top   <= under;
      end
      if (state == S_WAIT) begin
        under <= rdata;
      end
      if (do_clear) begin
        count <= '0;
        flag  <= 1'b0;
      end
    end
  end

endmodule
